FILE: hdl/i2p_pkg.sv
package i2p_pkg;

    // ASCII codes of the operator characters.
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Item classes produced by the front end.
    localparam logic [1:0] CLS_OPND  = 2'd0;
    localparam logic [1:0] CLS_OPEN  = 2'd1;
    localparam logic [1:0] CLS_CLOSE = 2'd2;
    localparam logic [1:0] CLS_OPER  = 2'd3;

    // Status codes carried on the last result of an item.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_CLOSE    = 2'd2;
    localparam logic [1:0] ST_OPEN     = 2'd3;

    // Queue between front end and sequencer.
    localparam int FQ_AW    = 1;
    localparam int FQ_DEPTH = 2 ** FQ_AW;

    // Result queue ahead of the output ports.
    localparam int OQ_AW    = 2;
    localparam int OQ_DEPTH = 2 ** OQ_AW;

    // One classified input item.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] cls;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       done;
        logic [1:0] status;
    } res_t;

endpackage

FILE: hdl/i2p_front.sv
module i2p_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_char,
    input  logic               expr_last,
    output i2p_pkg::item_t     head,
    output logic               empty,
    input  logic               pop
);
    import i2p_pkg::*;

    item_t              entry_reg [FQ_DEPTH];
    logic [FQ_AW-1:0]   wr_ptr_reg;
    logic [FQ_AW-1:0]   rd_ptr_reg;
    logic [FQ_AW:0]     cnt_reg;
    logic               do_push;
    logic               do_pop;
    item_t              new_item;

    // Classify the incoming character.
    always_comb
    begin
        new_item.ch   = in_char;
        new_item.last = expr_last;
        case (in_char)
            CH_OPEN:                         new_item.cls = CLS_OPEN;
            CH_CLOSE:                        new_item.cls = CLS_CLOSE;
            CH_MUL, CH_DIV, CH_ADD, CH_SUB:  new_item.cls = CLS_OPER;
            default:                         new_item.cls = CLS_OPND;
        endcase
    end

    assign full    = (cnt_reg == (FQ_AW+1)'(FQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= new_item;
    end

endmodule

FILE: hdl/i2p_outq.sv
module i2p_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enq,
    input  i2p_pkg::res_t      enq_data,
    output logic               full,
    output i2p_pkg::res_t      head,
    output logic               empty,
    input  logic               pop
);
    import i2p_pkg::*;

    res_t               entry_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg;
    logic [OQ_AW-1:0]   rd_ptr_reg;
    logic [OQ_AW:0]     cnt_reg;
    logic               do_enq;
    logic               do_pop;

    assign full   = (cnt_reg == (OQ_AW+1)'(OQ_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_enq = enq && !full;
    assign do_pop = pop && !empty;
    assign head   = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_enq && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_enq)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_enq)
            entry_reg[wr_ptr_reg] <= enq_data;
    end

endmodule

FILE: hdl/i2p_back.sv
module i2p_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  i2p_pkg::item_t     item,
    input  logic               item_empty,
    output logic               item_pop,
    output logic               res_enq,
    output i2p_pkg::res_t      res_data,
    input  logic               res_full
);
    import i2p_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLOSE = 3'd1;
    localparam logic [2:0] S_OPER  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Precedence of a character: 2 for * and /, 1 for + and -, else 0.
    function automatic logic [1:0] prec(input logic [7:0] c);
        logic [1:0] p;
        begin
            case (c)
                CH_MUL, CH_DIV:  p = 2'd2;
                CH_ADD, CH_SUB:  p = 2'd1;
                default:         p = 2'd0;
            endcase
            return p;
        end
    endfunction

    logic [7:0]     stack_mem [STACK_DEPTH];

    logic [2:0]     state_reg,      state_next;
    logic [7:0]     char_reg,       char_next;
    logic           last_reg,       last_next;
    logic [1:0]     err_reg,        err_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [7:0]     pend_char_reg,  pend_char_next;
    logic [CW-1:0]  count_reg,      count_next;
    logic [7:0]     tos_reg,        tos_next;
    logic [7:0]     below_reg;
    logic [CW-1:0]  rd_addr;

    logic           emit_en;
    logic [7:0]     emit_char;
    logic           fin_en;
    logic           push_en;
    logic [7:0]     push_char;
    logic           pop_en;
    logic           step;
    logic           stack_empty;
    logic           stack_full;
    logic [2:0]     post_state;

    assign step        = !res_full;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign post_state  = last_reg ? S_FLUSH : S_FIN;

    // Sequencer: one stack action or emit per cycle, stalled by res_full.
    always_comb
    begin
        state_next = state_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        emit_en    = 1'b0;
        emit_char  = tos_reg;
        fin_en     = 1'b0;
        push_en    = 1'b0;
        push_char  = char_reg;
        pop_en     = 1'b0;
        item_pop   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!item_empty && step)
                begin
                    item_pop  = 1'b1;
                    char_next = item.ch;
                    last_next = item.last;
                    err_next  = ST_OK;
                    case (item.cls)
                        CLS_OPND:
                        begin
                            emit_en    = 1'b1;
                            emit_char  = item.ch;
                            state_next = item.last ? S_FLUSH : S_FIN;
                        end
                        CLS_OPEN:
                        begin
                            if (!stack_full)
                            begin
                                push_en   = 1'b1;
                                push_char = item.ch;
                            end
                            else
                                err_next = ST_OVERFLOW;
                            state_next = item.last ? S_FLUSH : S_FIN;
                        end
                        CLS_CLOSE:  state_next = S_CLOSE;
                        default:    state_next = S_OPER;
                    endcase
                end
            end
            S_CLOSE:
            begin
                if (step)
                begin
                    if (stack_empty)
                    begin
                        if (err_reg == ST_OK)
                            err_next = ST_CLOSE;
                        state_next = post_state;
                    end
                    else if (tos_reg == CH_OPEN)
                    begin
                        pop_en     = 1'b1;
                        state_next = post_state;
                    end
                    else
                    begin
                        emit_en = 1'b1;
                        pop_en  = 1'b1;
                    end
                end
            end
            S_OPER:
            begin
                if (step)
                begin
                    if (!stack_empty && (prec(tos_reg) >= prec(char_reg)))
                    begin
                        emit_en = 1'b1;
                        pop_en  = 1'b1;
                    end
                    else
                    begin
                        if (!stack_full)
                            push_en = 1'b1;
                        else if (err_reg == ST_OK)
                            err_next = ST_OVERFLOW;
                        state_next = post_state;
                    end
                end
            end
            S_FLUSH:
            begin
                if (step)
                begin
                    if (stack_empty)
                        state_next = S_FIN;
                    else
                    begin
                        pop_en = 1'b1;
                        if (tos_reg == CH_OPEN)
                        begin
                            if (err_reg == ST_OK)
                                err_next = ST_OPEN;
                        end
                        else
                            emit_en = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (step)
                begin
                    fin_en     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A character is held back one step so that the last one of an item
    // can carry the end marks and the status.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        res_enq         = 1'b0;
        res_data.ch       = pend_char_reg;
        res_data.valid    = 1'b1;
        res_data.run_last = 1'b0;
        res_data.done     = 1'b0;
        res_data.status   = ST_OK;

        if (emit_en)
        begin
            res_enq         = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
        else if (fin_en)
        begin
            res_enq           = pend_valid_reg || (err_reg != ST_OK) || last_reg;
            res_data.ch       = pend_valid_reg ? pend_char_reg : 8'h00;
            res_data.valid    = pend_valid_reg;
            res_data.run_last = 1'b1;
            res_data.done     = last_reg;
            res_data.status   = err_reg;
            pend_valid_next   = 1'b0;
        end
    end

    // Stack pointer and top-of-stack register.
    always_comb
    begin
        count_next = count_reg;
        tos_next   = tos_reg;
        if (push_en)
        begin
            count_next = count_reg + 1'b1;
            tos_next   = push_char;
        end
        else if (pop_en)
        begin
            count_next = count_reg - 1'b1;
            tos_next   = below_reg;
        end
    end

    assign rd_addr = count_next - CW'(2);

    // Control and item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        err_reg       <= err_next;
        pend_char_reg <= pend_char_next;
        tos_reg       <= tos_next;
    end

    // Stack memory: every push is written; the entry just below the top
    // is read ahead so that a pop can refill the top register at once.
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[count_reg[AW-1:0]] <= push_char;
        if (count_next >= CW'(2))
            below_reg <= stack_mem[rd_addr[AW-1:0]];
    end

endmodule

FILE: hdl/infix_to_postfix_converter.sv
// Channel   Handshake            Fields
// input     push / full          in_char, expr_last
// result    pop / empty          out_char, char_valid, run_last, expr_done, status
//
// The sequencer takes one item at a time: it emits an operand, pushes a '(',
// pops and emits operators down to the '(' for a ')', pops those of equal or higher
// precedence before pushing an operator, and flushes the stack after a final item.
// A read-ahead register gives one stack pop per cycle while the output has room.
// Reset clears the queues, the stack pointer and the sequencer; no clearing
// pass is needed. Each side stalls on its own through the input and result queues.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_char,
    input  logic        expr_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic        run_last,
    output logic        expr_done,
    output logic [1:0]  status
);
    import i2p_pkg::*;

    item_t  item;
    logic   item_empty;
    logic   item_pop;
    logic   res_enq;
    res_t   res_data;
    logic   res_full;
    res_t   res_head;

    // Front end: classify characters and queue them.
    i2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_char   (in_char),
        .expr_last (expr_last),
        .head      (item),
        .empty     (item_empty),
        .pop       (item_pop)
    );

    // Back end: operator stack and sequencer.
    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .res_enq    (res_enq),
        .res_data   (res_data),
        .res_full   (res_full)
    );

    // Result queue toward the output ports.
    i2p_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (res_enq),
        .enq_data (res_data),
        .full     (res_full),
        .head     (res_head),
        .empty    (empty),
        .pop      (pop)
    );

    assign out_char   = res_head.ch;
    assign char_valid = res_head.valid;
    assign run_last   = res_head.run_last;
    assign expr_done  = res_head.done;
    assign status     = res_head.status;

endmodule
